>>> design/scanline_edge_table_fill_defines.svh
// Assertion macros shared by the scanline edge table fill design.
`ifndef SCANLINE_EDGE_TABLE_FILL_DEFINES_SVH
`define SCANLINE_EDGE_TABLE_FILL_DEFINES_SVH

// Same-cycle implication, checked on clk and held off during rst.
`define SETF_AST_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk and held off during rst.
`define SETF_AST_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/setf_pkg.sv
// Shared constants, widths, codes and types for the scanline edge table fill.
package setf_pkg;

  // Screen and fixed-point format.
  localparam int SCREEN_SIZE = 512;
  localparam int FRAC_BITS   = 16;
  localparam int COORD_W     = 9;
  localparam int ROW_W       = $clog2(SCREEN_SIZE);
  localparam int LEFT_W      = 10;
  localparam int RIGHT_W     = 9;
  localparam int CMD_W       = 2;

  // Running x and slope magnitude, and the widths used to compare against entries.
  localparam int XF_W      = COORD_W + FRAC_BITS;
  localparam int LCMP_W    = LEFT_W + FRAC_BITS;
  localparam int RCMP_W    = RIGHT_W + FRAC_BITS;
  localparam int DIV_CNT_W = $clog2(XF_W + 1);

  // Stream payload widths.
  localparam int IN_BITS   = 5 * COORD_W;
  localparam int S_TDATA_W = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS  = COORD_W + LEFT_W + RIGHT_W + 1;
  localparam int M_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  // Command codes carried in s_tuser.
  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR = 2'd0,
    CMD_EDGE  = 2'd1,
    CMD_READ  = 2'd2
  } cmd_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_WALK,
    ST_DRAIN,
    ST_READ,
    ST_RDCAP,
    ST_EMIT
  } st_t;

  // Write request into the edge tables.
  typedef struct packed {
    logic              en_left;
    logic              en_right;
    logic [ROW_W-1:0]  addr;
    logic [LEFT_W-1:0] left;
    logic [RIGHT_W-1:0] right;
  } tbl_wr_t;

endpackage

>>> design/scanline_edge_table_fill.sv
// Top level of the scanline edge table fill: sequencer, edge walk and stream ports.
//
//  Channel  Direction  Beat contents
//  s_*      in         tuser: command; tdata: x_start, y_start, x_end, y_end, row
//  m_*      out        tuser: done_res; tdata: row_out, span_left, span_right, span_present
//
// A clear writes one table row per cycle; a read steps through ST_READ and ST_RDCAP, and an
// unused command goes straight to ST_EMIT. An edge runs the bit-serial slope divider (skipped
// for a horizontal edge), then one row per cycle through the read-compare-write table walk.
// After reset a clearing pass over every table row runs before the first beat is taken.
// A result waits in the output register until taken; the next beat is taken meanwhile.
module scanline_edge_table_fill (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // From bit 0: x_start, y_start, x_end, y_end, row, zero fill.
  input  logic [setf_pkg::S_TDATA_W-1:0] s_tdata,
  // Command code.
  input  logic [setf_pkg::CMD_W-1:0]     s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // From bit 0: row_out, span_left, span_right, span_present, zero fill.
  output logic [setf_pkg::M_TDATA_W-1:0] m_tdata,
  // done_res.
  output logic                           m_tuser
);
  import setf_pkg::*;

  `include "scanline_edge_table_fill_defines.svh"

  st_t state, state_next;

  // Input beat fields.
  cmd_t               s_cmd;
  logic [COORD_W-1:0] in_xs, in_ys, in_xe, in_ye, in_row;
  logic [COORD_W-1:0] in_xa, in_ya, in_xb, in_yb, in_mag, in_dy;
  logic               in_neg;
  logic               accept;

  // Sequencer strobes.
  logic div_start, div_done, emit_load;
  logic [XF_W-1:0] div_quo;

  // Edge walk registers.
  logic [COORD_W-1:0] yb, r, row_q;
  logic               neg;
  logic [XF_W-1:0]    slope, x;
  logic               p_valid;
  logic [ROW_W-1:0]   p_addr;
  logic [XF_W-1:0]    p_x;
  logic [COORD_W-1:0] p_xi;
  logic               lower, raise;

  // Clearing sweep.
  logic [ROW_W-1:0] clr_addr;
  logic             clr_emit;

  // Table ports.
  tbl_wr_t            tbl_wr;
  logic [ROW_W-1:0]   rd_addr;
  logic [LEFT_W-1:0]  rd_left;
  logic [RIGHT_W-1:0] rd_right;

  // Staged result and output register.
  logic [COORD_W-1:0] res_row, out_row;
  logic [LEFT_W-1:0]  res_left, out_left;
  logic [RIGHT_W-1:0] res_right, out_right;
  logic               res_present, out_present;
  logic               res_done, out_done;

  // Unpack the beat and order the endpoints by y.
  always_comb begin
    s_cmd  = cmd_t'(s_tuser);
    in_xs  = s_tdata[COORD_W-1:0];
    in_ys  = s_tdata[2*COORD_W-1:COORD_W];
    in_xe  = s_tdata[3*COORD_W-1:2*COORD_W];
    in_ye  = s_tdata[4*COORD_W-1:3*COORD_W];
    in_row = s_tdata[5*COORD_W-1:4*COORD_W];
    if (in_ys > in_ye) begin
      in_xa = in_xe;
      in_ya = in_ye;
      in_xb = in_xs;
      in_yb = in_ys;
    end else begin
      in_xa = in_xs;
      in_ya = in_ys;
      in_xb = in_xe;
      in_yb = in_ye;
    end
    in_neg = in_xb < in_xa;
    in_mag = in_neg ? (in_xa - in_xb) : (in_xb - in_xa);
    in_dy  = in_yb - in_ya;
  end

  assign accept = s_tvalid & s_tready;

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and strobes.
  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    div_start  = 1'b0;
    emit_load  = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        if (clr_addr == ROW_W'(SCREEN_SIZE - 1)) begin
          state_next = clr_emit ? ST_EMIT : ST_IDLE;
        end
      end
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          unique case (s_cmd)
            CMD_CLEAR: state_next = ST_CLEAR;
            CMD_EDGE: begin
              if (in_dy != '0) begin
                div_start  = 1'b1;
                state_next = ST_DIV;
              end else begin
                state_next = ST_WALK;
              end
            end
            CMD_READ: state_next = ST_READ;
            default:  state_next = ST_EMIT;
          endcase
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_WALK;
        end
      end
      ST_WALK: begin
        if (r == yb) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: state_next = ST_EMIT;
      ST_READ:  state_next = ST_RDCAP;
      ST_RDCAP: state_next = ST_EMIT;
      ST_EMIT: begin
        if (!m_tvalid || m_tready) begin
          emit_load  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Slope divider: |dx| with the fraction appended, over dy.
  setf_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({in_mag, {FRAC_BITS{1'b0}}}),
    .divisor  (in_dy),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Clearing sweep control.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      clr_emit <= 1'b0;
    end else if (accept && s_cmd == CMD_CLEAR) begin
      clr_addr <= '0;
      clr_emit <= 1'b1;
    end else if (state == ST_CLEAR) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  // Walk registers: running x and row, advanced once per row.
  always_ff @(posedge clk) begin
    if (accept) begin
      row_q <= in_row;
      yb    <= in_yb;
      r     <= in_ya;
      x     <= {in_xa, {FRAC_BITS{1'b0}}};
      neg   <= in_neg;
      slope <= '0;
    end else begin
      if (div_done) begin
        slope <= div_quo;
      end
      if (state == ST_WALK) begin
        r <= r + 1'b1;
        x <= neg ? (x - slope) : (x + slope);
      end
    end
  end

  // Row in flight between table read and write-back.
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else begin
      p_valid <= (state == ST_WALK) && (int'(r) < SCREEN_SIZE);
    end
  end

  always_ff @(posedge clk) begin
    p_addr <= ROW_W'(r);
    p_x    <= x;
  end

  // Table read address: the walk row, otherwise the requested row.
  assign rd_addr = (state == ST_WALK) ? ROW_W'(r) : ROW_W'(row_q);

  // Compare the full fixed-point x against the stored entries, or write the clear sweep.
  always_comb begin
    p_xi  = p_x[XF_W-1:FRAC_BITS];
    lower = LCMP_W'(p_x) < {rd_left, {FRAC_BITS{1'b0}}};
    raise = RCMP_W'(p_x) > {rd_right, {FRAC_BITS{1'b0}}};
    if (state == ST_CLEAR) begin
      tbl_wr.en_left  = 1'b1;
      tbl_wr.en_right = 1'b1;
      tbl_wr.addr     = clr_addr;
      tbl_wr.left     = LEFT_W'(SCREEN_SIZE);
      tbl_wr.right    = '0;
    end else begin
      tbl_wr.en_left  = p_valid & lower;
      tbl_wr.en_right = p_valid & raise;
      tbl_wr.addr     = p_addr;
      tbl_wr.left     = LEFT_W'(p_xi);
      tbl_wr.right    = RIGHT_W'(p_xi);
    end
  end

  setf_tables u_tables (
    .clk      (clk),
    .wr       (tbl_wr),
    .rd_addr  (rd_addr),
    .rd_left  (rd_left),
    .rd_right (rd_right)
  );

  // Result staging: completion flag at accept, span after the table read.
  always_ff @(posedge clk) begin
    if (accept) begin
      res_row     <= '0;
      res_left    <= '0;
      res_right   <= '0;
      res_present <= 1'b0;
      res_done    <= (s_cmd == CMD_CLEAR) || (s_cmd == CMD_EDGE);
    end else if (state == ST_RDCAP) begin
      res_row <= row_q;
      if (int'(row_q) < SCREEN_SIZE) begin
        res_left    <= rd_left;
        res_right   <= rd_right;
        res_present <= rd_left < LEFT_W'(rd_right);
      end else begin
        res_left    <= LEFT_W'(SCREEN_SIZE);
        res_right   <= '0;
        res_present <= 1'b0;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      out_row     <= res_row;
      out_left    <= res_left;
      out_right   <= res_right;
      out_present <= res_present;
      out_done    <= res_done;
    end
  end

  assign m_tdata = {{(M_TDATA_W - OUT_BITS){1'b0}}, out_present, out_right, out_left, out_row};
  assign m_tuser = out_done;

  // Checks on the sequencer and datapath.
  `SETF_AST_IMP(a_div_done_in_div, div_done, state == ST_DIV, "divider finished outside divide")
  `SETF_AST_IMP(a_tbl_wr_ctx, tbl_wr.en_left || tbl_wr.en_right,
                state == ST_WALK || state == ST_DRAIN || state == ST_CLEAR,
                "table written outside clear or walk")
  `SETF_AST_IMP(a_span_present, m_tvalid && out_present, out_left < LEFT_W'(out_right),
                "span flagged present with left not below right")
  `SETF_AST_NXT(a_edge_start, accept && s_cmd == CMD_EDGE,
                state == ST_DIV || state == ST_WALK, "edge beat did not start divide or walk")

endmodule

>>> design/setf_div.sv
// Restoring divider that produces one quotient bit per cycle for the edge slope.
module setf_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [setf_pkg::XF_W-1:0]   dividend,
  input  logic [setf_pkg::COORD_W-1:0] divisor,
  output logic                        done,
  output logic [setf_pkg::XF_W-1:0]   quotient
);
  import setf_pkg::*;

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [COORD_W:0]     rem;
  logic [XF_W-1:0]      quo;
  logic [COORD_W-1:0]   dvs;
  logic [COORD_W:0]     rem_sh;
  logic [COORD_W+1:0]   diff;
  logic                 fit;

  // Shift in the next dividend bit and try to subtract the divisor.
  always_comb begin
    rem_sh = {rem[COORD_W-1:0], quo[XF_W-1]};
    diff   = {1'b0, rem_sh} - {2'b00, dvs};
    fit    = ~diff[COORD_W+1];
  end

  // Step counter and completion pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(XF_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Remainder and quotient shift register.
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= fit ? diff[COORD_W:0] : rem_sh;
      quo <= {quo[XF_W-2:0], fit};
    end
  end

  assign quotient = quo;

endmodule

>>> design/setf_tables.sv
// Left and right edge table memories with one write port and a registered read port.
module setf_tables (
  input  logic                         clk,
  input  setf_pkg::tbl_wr_t            wr,
  input  logic [setf_pkg::ROW_W-1:0]   rd_addr,
  output logic [setf_pkg::LEFT_W-1:0]  rd_left,
  output logic [setf_pkg::RIGHT_W-1:0] rd_right
);
  import setf_pkg::*;

  logic [LEFT_W-1:0]  left_mem  [SCREEN_SIZE];
  logic [RIGHT_W-1:0] right_mem [SCREEN_SIZE];

  // Left edge table.
  always_ff @(posedge clk) begin
    if (wr.en_left) begin
      left_mem[wr.addr] <= wr.left;
    end
    rd_left <= left_mem[rd_addr];
  end

  // Right edge table.
  always_ff @(posedge clk) begin
    if (wr.en_right) begin
      right_mem[wr.addr] <= wr.right;
    end
    rd_right <= right_mem[rd_addr];
  end

endmodule
